### rtl/tcpt_pkg.sv
// Package for the time code pulse transmitter: widths, register indexes,
// reset values, item and control types. No dependencies.
package tcpt_pkg;

    localparam int FRAME_BITS  = 38;
    localparam int SYM_W       = 2;
    localparam int NUM_SYMBOLS = FRAME_BITS / SYM_W;
    localparam int SYM_IDX_W   = 5;
    localparam int TICK_W      = 12;
    localparam int UNIT_W      = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_UNIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_PERIOD = 1'd1;

    localparam logic [UNIT_W-1:0] PULSE_UNIT_RESET    = 10'd100;
    localparam logic [TICK_W-1:0] SYMBOL_PERIOD_RESET = 12'd1000;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef logic [FRAME_BITS-1:0] t_frame;
    typedef logic [SYM_W-1:0]      t_sym;

    typedef struct packed {
        logic       command;
        logic [5:0] second_in;
        logic [5:0] minute_in;
        logic [4:0] hour_in;
        logic [2:0] weekday_in;
        logic [4:0] day_in;
        logic [3:0] month_in;
        logic [6:0] year_in_century;
    } t_in_item;

    typedef struct packed {
        logic                 signal_level;
        logic                 busy_res;
        logic [SYM_IDX_W-1:0] symbol_index;
        logic                 load_accepted;
    } t_out_item;

    // Control shared by every symbol cell.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

### rtl/tcpt_in_if.sv
// Input channel of the time code pulse transmitter: valid, ready, item.
// Depends on tcpt_pkg.
interface tcpt_in_if import tcpt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### rtl/tcpt_out_if.sv
// Result channel of the time code pulse transmitter: valid, ready, item.
// Depends on tcpt_pkg.
interface tcpt_out_if import tcpt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### rtl/tcpt_enc.sv
// Frame encoder: packs a calendar time into the 38-bit time code frame.
// Depends on tcpt_pkg.
module tcpt_enc import tcpt_pkg::*; (
    input  t_in_item i_time,
    output t_frame   o_frame
);

    logic [1:0]  w_sec20;
    logic [3:0]  w_hour12;
    logic        w_pm;
    logic [3:0]  w_wday;
    logic [3:0]  w_month;
    logic [17:0] w_head;
    logic [15:0] w_tail;

    always_comb begin
        // second / 20 for 0..63
        if (i_time.second_in >= 6'd60) begin
            w_sec20 = 2'd3;
        end else if (i_time.second_in >= 6'd40) begin
            w_sec20 = 2'd2;
        end else if (i_time.second_in >= 6'd20) begin
            w_sec20 = 2'd1;
        end else begin
            w_sec20 = 2'd0;
        end

        // hour mod 12 for 0..31
        if (i_time.hour_in >= 5'd24) begin
            w_hour12 = 4'(i_time.hour_in - 5'd24);
        end else if (i_time.hour_in >= 5'd12) begin
            w_hour12 = 4'(i_time.hour_in - 5'd12);
        end else begin
            w_hour12 = 4'(i_time.hour_in);
        end
        w_pm = (i_time.hour_in >= 5'd12);

        // Sunday goes out as 7
        w_wday  = (i_time.weekday_in == 3'd0) ? 4'd7 : {1'b0, i_time.weekday_in};
        w_month = i_time.month_in + 4'd1;

        w_head = {w_sec20, 2'b00, w_hour12, i_time.minute_in, w_wday};
        w_tail = {1'b0, i_time.day_in, w_month, i_time.year_in_century[5:0]};
    end

    assign o_frame = {w_head, w_pm, ^w_head, w_tail, 1'b0, ^w_tail};

endmodule

### rtl/tcpt_cell.sv
// One symbol cell of the frame chain: holds a two-bit symbol, loads it from
// the encoder and takes its neighbor's symbol on each shift. Depends on tcpt_pkg.
module tcpt_cell import tcpt_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_sym       i_load_sym,
    input  t_sym       i_next_sym,
    output t_sym       o_sym
);

    t_sym r_sym;
    t_sym n_sym;

    always_comb begin
        n_sym = r_sym;
        if (i_ctrl.load) begin
            n_sym = i_load_sym;
        end else if (i_ctrl.shift) begin
            n_sym = i_next_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

    assign o_sym = r_sym;

endmodule

### rtl/time_code_pulse_transmitter_core.sv
// Time code pulse transmitter, top level.
// Each accepted item's result is captured in the output register in the cycle after.
// Throughput: one item per cycle while the output register is free or drains; the tick
// counter add/compare and the symbol-level multiply by the pulse unit are combinational.
// Reset (synchronous, active low): idle, counters zero, pulse unit 100,
// symbol period 1000, output register empty.
module time_code_pulse_transmitter_core import tcpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tcpt_in_if.sink               i_item,
    tcpt_out_if.source            o_res
);

    // Configuration registers
    logic [UNIT_W-1:0] r_unit;
    logic [TICK_W-1:0] r_period;

    // Transmit state; the frame itself lives in the cell chain
    logic                 r_sending, n_sending;
    logic [SYM_IDX_W-1:0] r_cur_sym, n_cur_sym;
    logic [TICK_W-1:0]    r_tick, n_tick;

    // Output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    t_frame     w_frame;
    t_cell_ctrl w_ctrl;
    t_sym       w_sym [NUM_SYMBOLS];

    logic              w_fire;
    logic              w_is_load;
    logic              w_start;
    logic              w_step;
    logic [TICK_W-1:0] w_tick_inc;
    logic              w_wrap;
    logic              w_last;
    logic [2:0]        w_sym_inc;
    logic [UNIT_W+2:0] w_high;
    logic              w_level_cur;

    // Accept a new item whenever the output register is free or drains now.
    assign i_item.ready = !r_out_valid || o_res.ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    assign w_fire    = i_item.valid && i_item.ready;
    assign w_is_load = (i_item.data.command == CMD_LOAD);
    assign w_start   = w_fire && w_is_load && !r_sending;
    assign w_step    = w_fire && !w_is_load && r_sending;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit   <= PULSE_UNIT_RESET;
            r_period <= SYMBOL_PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PULSE_UNIT:    r_unit   <= i_cfg_data[UNIT_W-1:0];
                CFG_SYMBOL_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcpt_enc u_enc (
        .i_time  (i_item.data),
        .o_frame (w_frame)
    );

    // Chain of symbol cells: cell 0 holds the symbol on the air; on each symbol boundary
    // every cell takes its upper neighbor's symbol, and the top cell takes zero.
    assign w_ctrl.load  = w_start;
    assign w_ctrl.shift = w_step && w_wrap;

    for (genvar k = 0; k < NUM_SYMBOLS; k++) begin : g_cell
        t_sym w_next;
        if (k == NUM_SYMBOLS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_sym[k+1];
        end
        tcpt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_load_sym (w_frame[FRAME_BITS-1-SYM_W*k -: SYM_W]),
            .i_next_sym (w_next),
            .o_sym      (w_sym[k])
        );
    end

    // Key level at the current position: high while sending and tick < (symbol+1)*unit.
    assign w_sym_inc   = {1'b0, w_sym[0]} + 3'd1;
    assign w_high      = {{UNIT_W{1'b0}}, w_sym_inc} * {3'b000, r_unit};
    assign w_level_cur = r_sending && ({1'b0, r_tick} < w_high);

    assign w_tick_inc = r_tick + TICK_W'(1);
    assign w_wrap     = (w_tick_inc >= r_period);
    assign w_last     = (r_cur_sym == SYM_IDX_W'(NUM_SYMBOLS - 1));

    always_comb begin
        n_sending   = r_sending;
        n_cur_sym   = r_cur_sym;
        n_tick      = r_tick;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;

        if (w_start) begin
            n_sending = 1'b1;
            n_cur_sym = '0;
            n_tick    = '0;
        end else if (w_step) begin
            if (w_wrap) begin
                n_tick = '0;
                if (w_last) begin
                    // drop back to idle after the final symbol
                    n_cur_sym = '0;
                    n_sending = 1'b0;
                end else begin
                    n_cur_sym = r_cur_sym + SYM_IDX_W'(1);
                end
            end else begin
                n_tick = w_tick_inc;
            end
        end

        if (w_fire) begin
            n_out_valid = 1'b1;
            // a fresh frame starts at tick zero: high unless the unit is zero
            n_out.signal_level  = w_start ? (r_unit != '0) : w_level_cur;
            n_out.busy_res      = n_sending;
            n_out.symbol_index  = n_sending ? n_cur_sym : '0;
            n_out.load_accepted = w_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending   <= 1'b0;
            r_cur_sym   <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sending   <= n_sending;
            r_cur_sym   <= n_cur_sym;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTH
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_sym <= SYM_IDX_W'(NUM_SYMBOLS - 1))
        else $error("symbol index past end of frame");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_cur_sym == '0 && r_tick == '0))
        else $error("idle with stale counters");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_sending && r_cur_sym == '0 && r_out_valid && r_out.load_accepted))
        else $error("accepted load did not start a frame");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.load_accepted) |-> r_out.busy_res)
        else $error("load accepted without busy");
`endif

endmodule
